>>> rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the stride prefetch table.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int TABLE_ENTRIES  = 16;
    localparam int ADDR_BITS      = 48;
    localparam int IDX_BITS       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AGE_BITS       = 8;
    localparam int CONF_BITS      = 2;
    localparam int MULT_BITS      = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 4;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [AGE_BITS-1:0]  t_age;
    typedef logic [CONF_BITS-1:0] t_conf;
    typedef logic [MULT_BITS-1:0] t_mult;

    localparam t_age AGE_MAX = {AGE_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MULTIPLIER = CFG_INDEX_BITS'(1);

    localparam t_conf THRESHOLD_RESET  = CONF_BITS'(2);
    localparam t_mult MULTIPLIER_RESET = MULT_BITS'(4);

    typedef struct packed {
        t_addr instr_address;
        t_addr data_address;
    } t_item;

    typedef struct packed {
        t_conf threshold;
        t_mult multiplier;
    } t_cfg;

endpackage

>>> rtl/core/stride_prefetch_table.sv
// ----------------------------------------------------------------------------
// stride_prefetch_table
// Stride prefetcher with a reference prediction table keyed by load address.
// ----------------------------------------------------------------------------
// Each accepted miss item yields exactly one result item, in order. The table
// walker handles one item at a time: it searches every entry for tag and age,
// one entry per cycle, then selects, forms the stride difference, compares and
// updates, multiplies and adds. A two-entry input queue takes new items while
// the walker is busy, and the output register lets the next item proceed while
// a result waits. The configuration port is always ready; write it only while
// the block is idle.
module stride_prefetch_table import spt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  t_addr                     i_instr_address,
    input  t_addr                     i_data_address,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_prefetch_valid,
    output t_addr                     o_prefetch_address,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= THRESHOLD_RESET;
            r_cfg.multiplier <= MULTIPLIER_RESET;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            if (i_cfg_index == CFG_THRESHOLD) begin
                r_cfg.threshold <= i_cfg_data[CONF_BITS-1:0];
            end else if (i_cfg_index == CFG_MULTIPLIER) begin
                r_cfg.multiplier <= i_cfg_data[MULT_BITS-1:0];
            end
        end
    end

    spt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_instr_address (i_instr_address),
        .i_data_address  (i_data_address),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    spt_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_prefetch_valid   (o_prefetch_valid),
        .o_prefetch_address (o_prefetch_address)
    );

endmodule

>>> rtl/core/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front
// Input side: accepts miss items and holds them in a short queue until the
// table walker takes them.
// ----------------------------------------------------------------------------
module spt_front import spt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_addr i_instr_address,
    input  t_addr i_data_address,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    t_item                r_buf [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 push;
    logic                 pop;

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

    assign o_stall   = (r_count == CNT_FULL);
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= '{instr_address: i_instr_address,
                                 data_address:  i_data_address};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/spt_back.sv
// ----------------------------------------------------------------------------
// spt_back
// Table side: walks the prediction table one entry a cycle, picks the hit,
// empty or oldest entry, updates stride and confidence and forms the
// prefetch candidate in an output register.
// ----------------------------------------------------------------------------
module spt_back import spt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output logic  o_prefetch_valid,
    output t_addr o_prefetch_address
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SEL,
        S_DIFF,
        S_CMP,
        S_MUL,
        S_ADD
    } t_state;

    localparam t_idx IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);

    // table storage
    t_addr r_tag    [TABLE_ENTRIES];
    t_addr r_last   [TABLE_ENTRIES];
    t_addr r_stride [TABLE_ENTRIES];
    t_conf r_conf   [TABLE_ENTRIES];
    t_age  r_age    [TABLE_ENTRIES];

    t_state r_state;
    t_addr  r_pc;
    t_addr  r_addr;
    t_idx   r_idx;
    logic   r_hit;
    t_idx   r_hit_idx;
    logic   r_have_empty;
    t_idx   r_empty_idx;
    t_idx   r_oldest_idx;
    t_age   r_oldest_age;
    t_addr  r_diff;
    t_conf  r_new_conf;
    t_addr  r_new_stride;
    t_addr  r_prod;
    logic   r_out_valid;
    logic   r_out_pv;
    t_addr  r_out_addr;

    t_addr  cur_tag;
    logic   cur_match;
    t_age   cur_age;
    t_idx   sel;
    t_addr  cur_last;
    t_conf  thr;
    logic   stride_eq;
    t_conf  conf_next;
    t_addr  stride_next;
    logic   out_load;
    logic [ADDR_BITS+MULT_BITS-1:0] prod_full;

    always_comb begin
        cur_tag     = r_tag[r_idx];
        cur_match   = (cur_tag == r_pc);
        // a matching entry has its age cleared in this same step
        cur_age     = cur_match ? '0 : r_age[r_idx];
        cur_last    = r_last[r_idx];
        thr         = (i_cfg.threshold == '0) ? CONF_BITS'(1) : i_cfg.threshold;
        stride_eq   = (r_diff == r_stride[r_idx]);
        if (stride_eq) begin
            conf_next   = (r_conf[r_idx] < thr) ? r_conf[r_idx] + 1'b1 : r_conf[r_idx];
            stride_next = r_stride[r_idx];
        end else begin
            conf_next   = '0;
            stride_next = r_diff;
        end
        priority if (r_hit) begin
            sel = r_hit_idx;
        end else if (r_have_empty) begin
            sel = r_empty_idx;
        end else begin
            sel = r_oldest_idx;
        end
        prod_full = {{MULT_BITS{1'b0}}, r_new_stride} * {{ADDR_BITS{1'b0}}, i_cfg.multiplier};
        out_load  = (r_state == S_ADD) && (!r_out_valid || !i_stall);
    end

    assign o_q_pop            = (r_state == S_IDLE) && i_q_valid;
    assign o_valid            = r_out_valid;
    assign o_prefetch_valid   = r_out_pv;
    assign o_prefetch_address = r_out_addr;

    // table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                r_tag[j]    <= '0;
                r_last[j]   <= '0;
                r_stride[j] <= '0;
                r_conf[j]   <= '0;
                r_age[j]    <= '0;
            end
        end else begin
            unique case (r_state)
                S_WALK: begin
                    if (cur_match) begin
                        r_age[r_idx] <= '0;
                    end
                end
                S_SEL: begin
                    if (!r_hit) begin
                        // full table: age everyone but the victim
                        if (!r_have_empty) begin
                            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                                if (IDX_BITS'(j) != sel && r_age[j] != AGE_MAX) begin
                                    r_age[j] <= r_age[j] + 1'b1;
                                end
                            end
                        end
                        r_tag[sel]  <= r_pc;
                        r_last[sel] <= r_addr;
                        r_conf[sel] <= '0;
                        r_age[sel]  <= '0;
                    end
                end
                S_CMP: begin
                    r_conf[r_idx]   <= conf_next;
                    r_stride[r_idx] <= stride_next;
                    r_last[r_idx]   <= r_addr;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_have_empty <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_pc         <= i_q_item.instr_address;
                        r_addr       <= i_q_item.data_address;
                        r_idx        <= '0;
                        r_hit        <= 1'b0;
                        r_hit_idx    <= '0;
                        r_have_empty <= 1'b0;
                        r_empty_idx  <= '0;
                        r_oldest_idx <= '0;
                        r_oldest_age <= '0;
                        r_state      <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (cur_match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (cur_tag == '0) begin
                        r_have_empty <= 1'b1;
                        r_empty_idx  <= r_idx;
                    end
                    // strict compare keeps the lowest index on ties
                    if (cur_age > r_oldest_age) begin
                        r_oldest_age <= cur_age;
                        r_oldest_idx <= r_idx;
                    end
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_SEL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SEL: begin
                    r_idx   <= sel;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= (r_addr >= cur_last) ? r_addr - cur_last : cur_last - r_addr;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_new_conf   <= conf_next;
                    r_new_stride <= stride_next;
                    r_state      <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod_full[ADDR_BITS-1:0];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_out_pv    <= (r_new_conf >= thr);
                        r_out_addr  <= (r_new_conf >= thr) ? r_addr + r_prod : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/spt_checker.sv
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks of the stride prefetch table, bound to the top level.
// ----------------------------------------------------------------------------
module spt_checker import spt_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic                      o_prefetch_valid,
    input t_addr                     o_prefetch_address,
    input logic                      o_cfg_ready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prefetch_valid)
                               && $stable(o_prefetch_address))
        else $error("stalled result changed");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_prefetch_valid |-> o_prefetch_address == '0)
        else $error("address set without prefetch");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && o_cfg_ready)
        else $error("input blocked after reset");

endmodule

bind stride_prefetch_table spt_checker u_spt_checker (.*);
